FILE: rtl/dsrt_pkg.sv
// Package for the datagram slice reassembly tracker.
// Types, constants and controller/datapath interface structs; no dependencies.
`default_nettype none
package dsrt_pkg;

	localparam int SLOTS      = 8;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int MAX_SLICE  = 4096;
	localparam int WORD_W     = 64;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int WIDX_W     = $clog2(MAX_SLICE / WORD_W + 1);
	localparam int MADDR_W    = SLOT_W + WIDX_W;
	localparam int MDEPTH     = 1 << MADDR_W;
	localparam logic [WIDX_W-1:0] WORDS_LAST = WIDX_W'(MAX_SLICE / WORD_W);
	localparam logic [15:0] MAX_SLICE_V = 16'(MAX_SLICE);

	localparam logic [2:0] EV_REJECT   = 3'd0;
	localparam logic [2:0] EV_COMPLETE = 3'd1;
	localparam logic [2:0] EV_OVERFLOW = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_FULL     = 3'd4;

	localparam logic [1:0] ORD_UNKNOWN = 2'd0;
	localparam logic [1:0] ORD_LITTLE  = 2'd1;
	localparam logic [1:0] ORD_BIG     = 2'd2;

	localparam logic [1:0] CFG_TOTAL_LIMIT = 2'd0;
	localparam logic [1:0] CFG_SLICE_LIMIT = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

	localparam logic [20:0] TOTAL_LIMIT_RST = 21'd1048576;
	localparam logic [12:0] SLICE_LIMIT_RST = 13'd4096;
	localparam logic [15:0] TIMEOUT_RST     = 16'd300;
	localparam logic [15:0] HDR_LEN         = 16'd8;

	typedef struct packed {
		logic        command;
		logic [63:0] header_bytes;
		logic [15:0] datagram_length;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] frame_id;
		logic [20:0] received_bytes;
		logic [20:0] total_bytes;
		logic [1:0]  byte_order;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic scan_timeout;
		logic clr_run;
		logic dec;
		logic rd;
		logic sb;
		logic chk;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic can_push;
		logic held_v;
		logic expired;
		logic idx_last;
		logic arrival;
		logic dec_reject;
		logic dec_full;
		logic dec_retot;
		logic chk_over;
		logic chk_eq;
		logic clr_slot_done;
		logic clr_all_done;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/dsrt_ctrl.sv
// Sequencing state machine for the reassembly tracker.
// Depends on dsrt_pkg; drives dsrt_dp through cmd_t and reads sts_t.
`default_nettype none
module dsrt_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_stall,
	input  dsrt_pkg::sts_t  sts,
	output dsrt_pkg::cmd_t  cmd
);

	typedef enum logic [10:0] {
		ST_RSTCLR   = 11'b000_0000_0001,
		ST_IDLE     = 11'b000_0000_0010,
		ST_SCAN     = 11'b000_0000_0100,
		ST_CLR_SCAN = 11'b000_0000_1000,
		ST_DEC      = 11'b000_0001_0000,
		ST_CLR_TOT  = 11'b000_0010_0000,
		ST_RD       = 11'b000_0100_0000,
		ST_SB       = 11'b000_1000_0000,
		ST_CHK      = 11'b001_0000_0000,
		ST_CLR_END  = 11'b010_0000_0000,
		ST_FLUSH    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d, post_scan;

	assign in_stall  = (state_q != ST_IDLE);
	assign post_scan = sts.arrival ? ST_DEC : ST_FLUSH;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_RSTCLR: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_all_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.expired) begin
					if (sts.can_push) begin
						cmd.scan_timeout = 1'b1;
						state_d          = ST_CLR_SCAN;
					end
				end else begin
					cmd.scan_step = 1'b1;
					state_d       = sts.idx_last ? post_scan : ST_SCAN;
				end
			end
			ST_CLR_SCAN: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_slot_done) begin
					cmd.scan_step = 1'b1;
					state_d       = sts.idx_last ? post_scan : ST_SCAN;
				end
			end
			ST_DEC: begin
				if (sts.can_push) begin
					cmd.dec = 1'b1;
					if (sts.dec_reject || sts.dec_full) state_d = ST_FLUSH;
					else if (sts.dec_retot)             state_d = ST_CLR_TOT;
					else                                state_d = ST_RD;
				end
			end
			ST_CLR_TOT: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_slot_done) state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_SB;
			end
			ST_SB: begin
				cmd.sb  = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (sts.can_push) begin
					cmd.chk = 1'b1;
					state_d = (sts.chk_over || sts.chk_eq) ? ST_CLR_END : ST_FLUSH;
				end
			end
			ST_CLR_END: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_slot_done) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!sts.held_v) begin
					state_d = ST_IDLE;
				end else if (sts.can_push) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_RSTCLR;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

FILE: rtl/dsrt_dp.sv
// Datapath: config registers, pending entry table, slice map memory, result staging.
// Depends on dsrt_pkg; commanded by dsrt_ctrl.
`default_nettype none
module dsrt_dp (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dsrt_pkg::in_item_t    in_data,
	output dsrt_pkg::out_item_t   out_data,
	output logic                  out_valid,
	input  wire                   out_stall,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [1:0]            cfg_index,
	input  wire  [20:0]           cfg_data,
	input  dsrt_pkg::cmd_t        cmd,
	output dsrt_pkg::sts_t        sts
);

	localparam int SW = dsrt_pkg::SLOT_W;

	logic [20:0] total_limit_q;
	logic [12:0] slice_limit_q;
	logic [15:0] timeout_q;
	logic [1:0]  lock_q;

	dsrt_pkg::in_item_t in_q;

	logic [dsrt_pkg::SLOTS-1:0] valid_q;
	logic [15:0] frame_q [dsrt_pkg::SLOTS];
	logic [20:0] total_q [dsrt_pkg::SLOTS];
	logic [20:0] count_q [dsrt_pkg::SLOTS];
	logic [31:0] first_q [dsrt_pkg::SLOTS];

	logic [SW-1:0]  ptr_q;
	logic [12:0]    slice_q;
	logic [dsrt_pkg::MADDR_W-1:0] clr_q;

	logic [dsrt_pkg::WORD_W-1:0] mem [dsrt_pkg::MDEPTH];
	logic [dsrt_pkg::WORD_W-1:0] rd_q;

	dsrt_pkg::out_item_t out_q, held_q, res_new;
	logic out_v_q, held_v_q, take, push;

	// header decode
	logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
	logic [15:0] lf, ls, bf, bs, payload, fid, slc;
	logic [31:0] lt, bt, tot;
	logic lp, bp, ok, use_l;
	logic [1:0] new_lock;
	logic [dsrt_pkg::SLOTS-1:0] hit, retot_v;
	logic [SW-1:0] hit_idx, free_idx;
	logic hit_any, free_any;
	logic bit_set;
	logic [20:0] cnt_p, tot_p;
	logic [31:0] age;

	function automatic logic plaus(input logic [15:0] s, input logic [31:0] t,
			input logic [15:0] p, input logic [20:0] tl, input logic [12:0] sl);
		plaus = (t >= {16'd0, p}) && (t <= {11'd0, tl}) && (s <= {3'd0, sl})
			&& (s <= dsrt_pkg::MAX_SLICE_V);
	endfunction

	assign {b0, b1, b2, b3, b4, b5, b6, b7} = in_q.header_bytes;
	assign lf = {b1, b0};
	assign ls = {b3, b2};
	assign lt = {b7, b6, b5, b4};
	assign bf = {b0, b1};
	assign bs = {b2, b3};
	assign bt = {b4, b5, b6, b7};
	assign payload = in_q.datagram_length - dsrt_pkg::HDR_LEN;
	assign lp = plaus(ls, lt, payload, total_limit_q, slice_limit_q);
	assign bp = plaus(bs, bt, payload, total_limit_q, slice_limit_q);

	always_comb begin
		ok       = 1'b0;
		use_l    = 1'b0;
		new_lock = lock_q;
		case (lock_q)
			dsrt_pkg::ORD_LITTLE: begin
				ok    = lp;
				use_l = 1'b1;
			end
			dsrt_pkg::ORD_BIG: begin
				ok = bp;
			end
			default: begin
				if (lp && (!bp || ls <= bs)) begin
					ok       = 1'b1;
					use_l    = 1'b1;
					new_lock = dsrt_pkg::ORD_LITTLE;
				end else if (bp) begin
					ok       = 1'b1;
					new_lock = dsrt_pkg::ORD_BIG;
				end
			end
		endcase
	end

	assign fid = use_l ? lf : bf;
	assign slc = use_l ? ls : bs;
	assign tot = use_l ? lt : bt;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		hit_any  = 1'b0;
		free_any = 1'b0;
		for (int s = dsrt_pkg::SLOTS - 1; s >= 0; s--) begin
			hit[s]     = valid_q[s] && (frame_q[s] == fid);
			retot_v[s] = hit[s] && (total_q[s] != tot[20:0]);
			if (hit[s]) begin
				hit_idx = SW'(s);
				hit_any = 1'b1;
			end
			if (!valid_q[s]) begin
				free_idx = SW'(s);
				free_any = 1'b1;
			end
		end
	end

	assign cnt_p   = count_q[ptr_q];
	assign tot_p   = total_q[ptr_q];
	assign age     = in_q.now_ms - first_q[ptr_q];
	assign bit_set = rd_q[slice_q[dsrt_pkg::BIT_W-1:0]];

	assign sts.expired       = valid_q[ptr_q] && (age > {16'd0, timeout_q});
	assign sts.idx_last      = (ptr_q == SW'(dsrt_pkg::SLOTS - 1));
	assign sts.arrival       = !in_q.command && (in_q.datagram_length > dsrt_pkg::HDR_LEN);
	assign sts.dec_reject    = !ok;
	assign sts.dec_full      = ok && !hit_any && !free_any;
	assign sts.dec_retot     = ok && (|retot_v);
	assign sts.chk_over      = cnt_p > tot_p;
	assign sts.chk_eq        = cnt_p == tot_p;
	assign sts.clr_slot_done = (clr_q[dsrt_pkg::WIDX_W-1:0] == dsrt_pkg::WORDS_LAST);
	assign sts.clr_all_done  = &clr_q;
	assign sts.held_v        = held_v_q;

	assign take         = out_v_q && !out_stall;
	assign sts.can_push = !held_v_q || !out_v_q || take;
	assign out_valid    = out_v_q;
	assign out_data     = out_q;
	assign cfg_ready    = 1'b1;

	always_comb begin
		res_new                = '0;
		res_new.byte_order     = lock_q;
		res_new.frame_id       = frame_q[ptr_q];
		res_new.received_bytes = cnt_p;
		res_new.total_bytes    = tot_p;
		push                   = 1'b0;
		if (cmd.scan_timeout) begin
			push              = 1'b1;
			res_new.event_res = dsrt_pkg::EV_TIMEOUT;
		end else if (cmd.dec) begin
			res_new.byte_order     = new_lock;
			res_new.frame_id       = fid;
			res_new.received_bytes = '0;
			res_new.total_bytes    = tot[20:0];
			if (!ok) begin
				push                = 1'b1;
				res_new.event_res   = dsrt_pkg::EV_REJECT;
				res_new.frame_id    = '0;
				res_new.total_bytes = '0;
			end else if (!hit_any && !free_any) begin
				push              = 1'b1;
				res_new.event_res = dsrt_pkg::EV_FULL;
			end
		end else if (cmd.chk) begin
			push              = sts.chk_over || sts.chk_eq;
			res_new.event_res = sts.chk_over ? dsrt_pkg::EV_OVERFLOW : dsrt_pkg::EV_COMPLETE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_limit_q <= dsrt_pkg::TOTAL_LIMIT_RST;
			slice_limit_q <= dsrt_pkg::SLICE_LIMIT_RST;
			timeout_q     <= dsrt_pkg::TIMEOUT_RST;
			lock_q        <= dsrt_pkg::ORD_UNKNOWN;
			valid_q       <= '0;
			ptr_q         <= '0;
			clr_q         <= '0;
			out_v_q       <= 1'b0;
			held_v_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					dsrt_pkg::CFG_TOTAL_LIMIT: total_limit_q <= cfg_data;
					dsrt_pkg::CFG_SLICE_LIMIT: slice_limit_q <= cfg_data[12:0];
					dsrt_pkg::CFG_TIMEOUT:     timeout_q     <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.accept)    ptr_q <= '0;
			if (cmd.scan_step) ptr_q <= ptr_q + 1'b1;
			if (cmd.clr_run)   clr_q <= clr_q + 1'b1;
			if (cmd.scan_timeout) begin
				valid_q[ptr_q] <= 1'b0;
				clr_q          <= {ptr_q, dsrt_pkg::WIDX_W'(0)};
			end
			if (cmd.dec) begin
				lock_q <= new_lock;
				if (ok && hit_any) begin
					ptr_q <= hit_idx;
					if (|retot_v) clr_q <= {hit_idx, dsrt_pkg::WIDX_W'(0)};
				end else if (ok && free_any) begin
					ptr_q             <= free_idx;
					valid_q[free_idx] <= 1'b1;
				end
			end
			if (cmd.chk && (sts.chk_over || sts.chk_eq)) begin
				valid_q[ptr_q] <= 1'b0;
				clr_q          <= {ptr_q, dsrt_pkg::WIDX_W'(0)};
			end
			if ((push && held_v_q) || cmd.flush) out_v_q <= 1'b1;
			else if (take)                       out_v_q <= 1'b0;
			if (push)           held_v_q <= 1'b1;
			else if (cmd.flush) held_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) in_q <= in_data;
		if (cmd.dec) begin
			slice_q <= slc[12:0];
			if (ok && hit_any && (|retot_v)) begin
				total_q[hit_idx] <= tot[20:0];
				count_q[hit_idx] <= '0;
				first_q[hit_idx] <= in_q.now_ms;
			end else if (ok && !hit_any && free_any) begin
				frame_q[free_idx] <= fid;
				total_q[free_idx] <= tot[20:0];
				count_q[free_idx] <= '0;
				first_q[free_idx] <= in_q.now_ms;
			end
		end
		if (cmd.sb && !bit_set) count_q[ptr_q] <= cnt_p + {5'd0, payload};
		if (push) held_q <= res_new;
		if (push && held_v_q) begin
			out_q <= {held_q[$bits(dsrt_pkg::out_item_t)-1:1], 1'b0};
		end else if (cmd.flush) begin
			out_q <= {held_q[$bits(dsrt_pkg::out_item_t)-1:1], 1'b1};
		end
	end

	// slice map: one 64-bit word per 64 slice indexes, 65 words per slot
	always_ff @(posedge clk) begin
		if (cmd.clr_run) begin
			mem[clr_q] <= '0;
		end else if (cmd.sb && !bit_set) begin
			mem[{ptr_q, slice_q[12:dsrt_pkg::BIT_W]}] <=
				rd_q | (dsrt_pkg::WORD_W'(1) << slice_q[dsrt_pkg::BIT_W-1:0]);
		end
		if (cmd.rd) rd_q <= mem[{ptr_q, slice_q[12:dsrt_pkg::BIT_W]}];
	end

endmodule
`default_nettype wire

FILE: rtl/datagram_slice_reassembly_tracker.sv
// Top level of the datagram slice reassembly tracker.
// Depends on dsrt_pkg, dsrt_ctrl and dsrt_dp.
//
//  channel  handshake            payload
//  in       in_valid / in_stall  in_data   (dsrt_pkg::in_item_t)
//  out      out_valid/ out_stall out_data  (dsrt_pkg::out_item_t)
//  cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One transaction at a time. Each scans every slot for a timeout and clears the map
// of each timed-out slot. An arrival is then decoded; unless it is rejected or the
// table is full, its slice bit is read and set and the count checked, and the slot
// map is cleared on a total change, completion or overflow. Map clearing runs one
// word per cycle. After reset a pass clears the slice map memory; in_stall stays high.
// Work pauses while the output register and the one-deep result stage are full.
`default_nettype none
module datagram_slice_reassembly_tracker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  dsrt_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output dsrt_pkg::out_item_t  out_data,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [1:0]           cfg_index,
	input  wire  [20:0]          cfg_data
);

	dsrt_pkg::cmd_t cmd;
	dsrt_pkg::sts_t sts;

	dsrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsrt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

FILE: verif/tb_datagram_slice_reassembly_tracker.sv
// Self-checking testbench for datagram_slice_reassembly_tracker.
// Depends on dsrt_pkg and the RTL top; a scoreboard class predicts the events of each
// accepted transaction and checks every output transaction against them in order.
`timescale 1ns / 1ps
module tb_datagram_slice_reassembly_tracker;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int NFRAMES      = 12;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	dsrt_pkg::in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	dsrt_pkg::out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [20:0] cfg_data;

	int errors;
	int cycles;
	bit hold_out;

	task automatic report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	class tracker_scoreboard;
		logic [20:0] total_lim;
		logic [12:0] slice_lim;
		logic [15:0] tmo;
		logic [1:0]  lock;
		bit          valid_e [dsrt_pkg::SLOTS];
		logic [15:0] frame_e [dsrt_pkg::SLOTS];
		logic [31:0] total_e [dsrt_pkg::SLOTS];
		logic [31:0] count_e [dsrt_pkg::SLOTS];
		logic [31:0] seen_t  [dsrt_pkg::SLOTS];
		bit [dsrt_pkg::MAX_SLICE:0] map_e [dsrt_pkg::SLOTS];
		dsrt_pkg::out_item_t   pending[$];

		function new();
			total_lim = dsrt_pkg::TOTAL_LIMIT_RST;
			slice_lim = dsrt_pkg::SLICE_LIMIT_RST;
			tmo = dsrt_pkg::TIMEOUT_RST;
			lock = dsrt_pkg::ORD_UNKNOWN;
			for (int s = 0; s < dsrt_pkg::SLOTS; s++) begin
				valid_e[s] = 0;
				map_e[s] = '0;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [20:0] v);
			if (idx == dsrt_pkg::CFG_TOTAL_LIMIT) total_lim = v;
			else if (idx == dsrt_pkg::CFG_SLICE_LIMIT) slice_lim = v[12:0];
			else if (idx == dsrt_pkg::CFG_TIMEOUT) tmo = v[15:0];
		endfunction

		function void emit(logic [2:0] ev, logic [31:0] fid, logic [31:0] rcv, logic [31:0] tot);
			dsrt_pkg::out_item_t r;
			r.event_res = ev;
			r.frame_id = fid[15:0];
			r.received_bytes = rcv[20:0];
			r.total_bytes = tot[20:0];
			r.byte_order = lock;
			r.last = 0;
			pending = {pending, r};
		endfunction

		function bit fits(logic [31:0] sl, logic [31:0] tot, logic [31:0] pay);
			return !(tot < pay || tot > total_lim || sl > slice_lim || sl > dsrt_pkg::MAX_SLICE);
		endfunction

		function void note_input(dsrt_pkg::in_item_t it);
			int n, slot, base;
			logic [7:0]  b [8];
			logic [31:0] lf, ls, lt, bf, bs, bt, pay, fid, sl, tot;
			bit lp, bp, ok, little;
			n = 0;
			base = pending.size();
			for (int s = 0; s < dsrt_pkg::SLOTS && n < 9; s++)
				if (valid_e[s] && (it.now_ms - seen_t[s]) > {16'd0, tmo}) begin
					emit(dsrt_pkg::EV_TIMEOUT, {16'd0, frame_e[s]}, count_e[s], total_e[s]);
					n++;
					valid_e[s] = 0;
					map_e[s] = '0;
				end
			if (it.command == 1'b0 && it.datagram_length > dsrt_pkg::HDR_LEN) begin
				pay = {16'd0, it.datagram_length - dsrt_pkg::HDR_LEN};
				for (int i = 0; i < 8; i++) b[i] = it.header_bytes[63 - 8*i -: 8];
				lf = {16'd0, b[1], b[0]}; ls = {16'd0, b[3], b[2]};
				lt = {b[7], b[6], b[5], b[4]};
				bf = {16'd0, b[0], b[1]}; bs = {16'd0, b[2], b[3]};
				bt = {b[4], b[5], b[6], b[7]};
				lp = fits(ls, lt, pay);
				bp = fits(bs, bt, pay);
				ok = 0; little = 0;
				if (lock == dsrt_pkg::ORD_LITTLE) begin ok = lp; little = 1; end
				else if (lock == dsrt_pkg::ORD_BIG) ok = bp;
				else if (lp && (!bp || ls <= bs)) begin
					ok = 1; little = 1; lock = dsrt_pkg::ORD_LITTLE;
				end
				else if (bp) begin ok = 1; lock = dsrt_pkg::ORD_BIG; end
				if (!ok) begin
					emit(dsrt_pkg::EV_REJECT, 32'd0, 32'd0, 32'd0);
					n++;
				end else begin
					fid = little ? lf : bf;
					sl = little ? ls : bs;
					tot = little ? lt : bt;
					slot = -1;
					for (int s = 0; s < dsrt_pkg::SLOTS; s++)
						if (slot < 0 && valid_e[s] && frame_e[s] == fid[15:0]) slot = s;
					if (slot < 0) begin
						for (int s = 0; s < dsrt_pkg::SLOTS; s++)
							if (slot < 0 && !valid_e[s]) slot = s;
						if (slot >= 0) begin
							valid_e[slot] = 1; frame_e[slot] = fid[15:0]; total_e[slot] = tot;
							count_e[slot] = 0; seen_t[slot] = it.now_ms; map_e[slot] = '0;
						end
					end else if (total_e[slot] != tot) begin
						total_e[slot] = tot; count_e[slot] = 0;
						seen_t[slot] = it.now_ms; map_e[slot] = '0;
					end
					if (slot < 0) begin
						emit(dsrt_pkg::EV_FULL, fid, 32'd0, tot);
						n++;
					end else begin
						if (!map_e[slot][sl]) begin
							map_e[slot][sl] = 1;
							count_e[slot] += pay;
						end
						if (count_e[slot] > total_e[slot]) begin
							emit(dsrt_pkg::EV_OVERFLOW, fid, count_e[slot], total_e[slot]);
							n++; valid_e[slot] = 0; map_e[slot] = '0;
						end else if (count_e[slot] == total_e[slot]) begin
							emit(dsrt_pkg::EV_COMPLETE, fid, count_e[slot], total_e[slot]);
							n++; valid_e[slot] = 0; map_e[slot] = '0;
						end
					end
				end
			end
			if (n > 0) pending[base + n - 1].last = 1;
		endfunction

		task check_result(dsrt_pkg::out_item_t got);
			dsrt_pkg::out_item_t exp_r;
			if (pending.size() == 0) begin
				report($sformatf("unexpected event %0d frame %h", got.event_res, got.frame_id));
				return;
			end
			exp_r = pending.pop_front();
			if (got.event_res !== exp_r.event_res)
				report($sformatf("event_res %0d, want %0d", got.event_res, exp_r.event_res));
			if (got.frame_id !== exp_r.frame_id)
				report($sformatf("frame_id %h, want %h", got.frame_id, exp_r.frame_id));
			if (got.received_bytes !== exp_r.received_bytes)
				report($sformatf("received_bytes %0d, want %0d",
					got.received_bytes, exp_r.received_bytes));
			if (got.total_bytes !== exp_r.total_bytes)
				report($sformatf("total_bytes %0d, want %0d", got.total_bytes, exp_r.total_bytes));
			if (got.byte_order !== exp_r.byte_order)
				report($sformatf("byte_order %0d, want %0d", got.byte_order, exp_r.byte_order));
			if (got.last !== exp_r.last)
				report($sformatf("last %0b, want %0b", got.last, exp_r.last));
		endtask
	endclass

	tracker_scoreboard sb;

	logic [15:0] fid_pool [NFRAMES];
	logic [31:0] tot_pool [NFRAMES];
	logic [15:0] pay_pool [NFRAMES];
	int          nsl_pool [NFRAMES];
	logic [31:0] now_t;

	datagram_slice_reassembly_tracker uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("datagram_slice_reassembly_tracker regression: fail");
			$finish;
		end
	end

	// output stall pattern: free runs, short stalls, occasional long ones
	initial begin
		int r, len;
		bit st;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 9);
			st = (r >= 4);
			len = (r < 4) ? $urandom_range(1, 30) : (r < 9) ? $urandom_range(1, 3)
				: $urandom_range(20, 60);
			repeat (len) begin
				@(posedge clk);
				out_stall <= st | hold_out;
			end
		end
	end

	always @(negedge clk)
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);

	function automatic logic [63:0] hdr(logic [15:0] fid, logic [15:0] sl, logic [31:0] tot,
		bit little);
		if (little)
			return {fid[7:0], fid[15:8], sl[7:0], sl[15:8],
				tot[7:0], tot[15:8], tot[23:16], tot[31:24]};
		return {fid, sl, tot};
	endfunction

	task automatic send(logic cmd, logic [63:0] h, logic [15:0] len);
		int r, gap;
		bit acc;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{command: cmd, header_bytes: h, datagram_length: len, now_ms: now_t};
		do begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
		end while (!acc);
		sb.note_input('{command: cmd, header_bytes: h, datagram_length: len, now_ms: now_t});
	endtask

	task automatic send_frame(logic [15:0] fid, logic [15:0] sl, logic [31:0] tot,
		logic [15:0] pay);
		send(1'b0, hdr(fid, sl, tot, sb.lock != dsrt_pkg::ORD_BIG), pay + dsrt_pkg::HDR_LEN);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [20:0] v);
		bit acc;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic new_frame(int k);
		pay_pool[k] = 16'($urandom_range(1, 200));
		nsl_pool[k] = $urandom_range(1, 4);
		tot_pool[k] = pay_pool[k] * nsl_pool[k];
	endtask

	task automatic random_items(int count);
		int r, k;
		logic [15:0] sl;
		repeat (count) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, NFRAMES - 1);
			if ($urandom_range(0, 99) < 3) now_t += sb.tmo + $urandom_range(1, 500);
			else now_t += $urandom_range(0, 20);
			if (r < 70) begin
				sl = 16'($urandom_range(0, nsl_pool[k] - 1));
				send_frame(fid_pool[k], sl, tot_pool[k], pay_pool[k]);
			end else if (r < 75) begin
				sl = 16'(nsl_pool[k] + $urandom_range(0, 3));
				send_frame(fid_pool[k], sl, tot_pool[k], pay_pool[k]);
			end else if (r < 80) begin
				new_frame(k);
				send_frame(fid_pool[k], 16'd0, tot_pool[k], pay_pool[k]);
			end else if (r < 85) begin
				send(1'b1, {$urandom, $urandom}, 16'($urandom_range(0, 65507)));
			end else if (r < 90) begin
				send(1'b0, {$urandom, $urandom}, 16'($urandom_range(0, 65507)));
			end else if (r < 95) begin
				send(1'b0, {$urandom, $urandom}, 16'($urandom_range(0, 8)));
			end else begin
				sl = 16'({3'd0, sb.slice_lim} + $urandom_range(0, 1));
				send_frame(fid_pool[k], sl, 32'd500, 16'd100);
			end
		end
	endtask

	initial begin
		sb = new();
		errors = 0;
		cycles = 0;
		hold_out = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = dsrt_pkg::CFG_TOTAL_LIMIT;
		cfg_data = '0;
		now_t = 32'hFFFF_F000;
		for (int k = 0; k < NFRAMES; k++) begin
			fid_pool[k] = 16'(k * 5461 + $urandom_range(0, 5000));
			new_frame(k);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: short datagrams, reject, lock with both readings valid
		send(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd8);
		send(1'b0, 64'h0123_4567_89AB_CDEF, 16'd0);
		send(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd65507);
		send(1'b0, 64'h0000_0000_0000_0000, 16'd9);
		send(1'b0, 64'h1234_0000_0001_0100, 16'd1008);
		send_frame(16'hFFFF, 16'd0, 32'd300, 16'd300);
		send_frame(16'h0000, 16'd0, 32'd200, 16'd100);
		send_frame(16'h0000, 16'd0, 32'd200, 16'd100);
		send_frame(16'h0000, 16'd1, 32'd200, 16'd100);
		send_frame(16'h0042, 16'd0, 32'd400, 16'd100);
		send_frame(16'h0042, 16'd1, 32'd900, 16'd100);
		send_frame(16'h0042, 16'd5, 32'd150, 16'd100);
		send_frame(16'h0042, 16'd6, 32'd150, 16'd100);
		send_frame(16'h0077, 16'd4096, 32'd64, 16'd32);
		send_frame(16'h0077, 16'd4097, 32'd64, 16'd32);
		for (int i = 0; i < 9; i++) send_frame(16'(16'h0100 + i), 16'd0, 32'd1000, 16'd10);
		now_t += 32'd301;
		send(1'b1, 64'h0, 16'd0);
		settle();

		write_reg(dsrt_pkg::CFG_TOTAL_LIMIT, 21'd1048576);
		write_reg(dsrt_pkg::CFG_SLICE_LIMIT, 21'd4096);
		write_reg(dsrt_pkg::CFG_TIMEOUT, 21'd65535);
		send_frame(16'h0200, 16'd0, 32'd1048576, 16'd65499);
		random_items(110);
		settle();

		write_reg(dsrt_pkg::CFG_TOTAL_LIMIT, 21'd0);
		write_reg(dsrt_pkg::CFG_SLICE_LIMIT, 21'd0);
		write_reg(dsrt_pkg::CFG_TIMEOUT, 21'd0);
		random_items(15);
		settle();

		write_reg(dsrt_pkg::CFG_TOTAL_LIMIT, 21'($urandom_range(5000, 1048576)));
		write_reg(dsrt_pkg::CFG_SLICE_LIMIT, 21'($urandom_range(8, 4096)));
		write_reg(dsrt_pkg::CFG_TIMEOUT, 21'($urandom_range(50, 2000)));
		fork
			begin
				repeat (50) @(posedge clk);
				hold_out = 1;
				repeat (600) @(posedge clk);
				hold_out = 0;
			end
			random_items(160);
		join
		settle();

		if (errors == 0 && sb.pending.size() == 0)
			$display("datagram_slice_reassembly_tracker regression: pass");
		else begin
			if (sb.pending.size() != 0) report("expected events never arrived");
			$display("datagram_slice_reassembly_tracker regression: fail");
		end
		$finish;
	end
endmodule
